/* design/p2r_pkg.sv */
package p2r_pkg;

    localparam int PLANE_BYTES_W = 64;
    localparam int IDX_W         = 8;
    localparam int RGB_W         = 15;
    localparam int COMP_W        = 5;
    localparam int LANES         = 8;
    localparam int CNT_W         = 4;
    localparam int WIDTH_W       = 15;
    localparam int PLANES_W      = 4;
    localparam int SEEN_W        = 13;
    localparam int CFG_AW        = 4;
    localparam int CFG_DW        = 32;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_NUM_PLANES   = 2'd1;
    localparam logic [1:0] REG_IMAGE_FORMAT = 2'd2;

    localparam logic FMT_PLANAR = 1'b0;
    localparam logic FMT_CHUNKY = 1'b1;

    localparam logic REQ_PAL_WRITE = 1'b0;
    localparam logic REQ_IMAGE     = 1'b1;

    // One unit of work handed from the front end to the pixel serializer.
    typedef struct packed {
        logic                             is_pal;
        logic [LANES-1:0][IDX_W-1:0]      idx;
        logic [CNT_W-1:0]                 cnt;
        logic                             rend;
        logic [RGB_W-1:0]                 color;
    } job_t;

endpackage

/* design/p2r_lane.sv */
module p2r_lane
    import p2r_pkg::*;
#(
    parameter int BIT_POS    = 7,
    parameter int MAX_PLANES = 8
) (
    input  logic [PLANE_BYTES_W-1:0] plane_bytes,
    input  logic [PLANES_W-1:0]      planes,
    output logic [IDX_W-1:0]         idx
);

    // Plane k contributes bit k of the color index; planes beyond the
    // active count read as zero.
    always_comb begin
        idx = '0;
        for (int k = 0; k < MAX_PLANES; k++) begin
            if (PLANES_W'(k) < planes) begin
                idx[k] = plane_bytes[8*k + BIT_POS];
            end
        end
    end

endmodule

/* design/p2r_serializer.sv */
module p2r_serializer
    import p2r_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             job_valid,
    input  job_t             job,
    output logic             job_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [RGB_W-1:0] out_rgb,
    output logic             out_last,
    output logic             out_rend
);

    localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W+1)'(PALETTE_DEPTH);

    logic [RGB_W-1:0] palette_mem [PALETTE_DEPTH];

    logic             busy_reg;
    job_t             cur_reg;
    logic [CNT_W-1:0] pos_reg;

    logic             rd_valid_reg;
    logic             rd_hit_reg;
    logic             rd_last_reg;
    logic             rd_rend_reg;
    logic [RGB_W-1:0] rd_data_reg;

    logic             out_valid_reg;
    logic [RGB_W-1:0] out_rgb_reg;
    logic             out_last_reg;
    logic             out_rend_reg;

    logic             out_free;
    logic             rd_free;
    logic             issue;
    logic             issue_last;
    logic             take;
    logic [IDX_W-1:0] cur_idx;
    logic             cur_hit;
    logic             wr_hit;

    assign out_free   = !out_valid_reg || out_ready;
    assign rd_free    = !rd_valid_reg || out_free;
    assign issue      = busy_reg && rd_free;
    assign issue_last = (pos_reg == (cur_reg.cnt - CNT_W'(1)));
    assign job_ready  = !busy_reg || (issue && issue_last);
    assign take       = job_valid && job_ready;
    assign cur_idx    = cur_reg.idx[pos_reg[2:0]];
    assign cur_hit    = ({1'b0, cur_idx} < IDX_LIMIT);
    assign wr_hit     = ({1'b0, job.idx[0]} < IDX_LIMIT);

    // A palette write lands when its transfer reaches this stage, so every
    // pixel ahead of it has already been read from the old contents.
    always_ff @(posedge aclk) begin
        if (take && job.is_pal && wr_hit) begin
            palette_mem[job.idx[0][PAL_AW-1:0]] <= job.color;
        end
        if (issue) begin
            rd_data_reg <= palette_mem[cur_idx[PAL_AW-1:0]];
            rd_hit_reg  <= cur_hit;
            rd_last_reg <= issue_last;
            rd_rend_reg <= issue_last && cur_reg.rend;
        end
        if (take) begin
            cur_reg <= job;
        end
        if (rd_valid_reg && out_free) begin
            out_rgb_reg  <= rd_hit_reg ? rd_data_reg : '0;
            out_last_reg <= rd_last_reg;
            out_rend_reg <= rd_rend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                busy_reg <= !job.is_pal;
                pos_reg  <= '0;
            end else if (issue) begin
                busy_reg <= !issue_last;
                pos_reg  <= pos_reg + CNT_W'(1);
            end

            if (issue) begin
                rd_valid_reg <= 1'b1;
            end else if (out_free) begin
                rd_valid_reg <= 1'b0;
            end

            if (rd_valid_reg && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rgb   = out_rgb_reg;
    assign out_last  = out_last_reg;
    assign out_rend  = out_rend_reg;

endmodule

/* design/planar_to_rgb15_converter.sv */
// Planar or chunky bitmap rows in, 15-bit RGB pixels out, one pixel per
// cycle unless the output stalls. A planar transfer carries one byte column
// of every bitplane; eight lanes build the eight color indexes at once and
// the row counters decide how many of them (up to eight) belong to the row;
// the input is held off while they are read one at a time through the single
// read port of the palette memory. Padding columns past the row's last
// pixel, zero-width rows and palette writes give no pixels; a chunky
// transfer gives a single pixel. Pixels pass the job, current-job, palette
// read and output registers on their way out. Palette writes stay in order
// with the pixels around them. Palette entries never written read as garbage;
// a write to any configuration register restarts the current row. Configure only while idle.
module planar_to_rgb15_converter
    import p2r_pkg::*;
#(
    parameter int MAX_PLANES    = 8,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    // APB-style configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    // Input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    // plane_bytes[63:0], pal_index[71:64], pal_red[79:72], pal_green[87:80],
    // pal_blue[95:88]
    input  logic [95:0]       s_tdata,
    // req_type[0]
    input  logic              s_tuser,
    // Output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    // pixel_rgb15[14:0], zero[15]
    output logic [15:0]       m_tdata,
    // last_of_run
    output logic              m_tlast,
    // row_end[0]
    output logic              m_tuser
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [PLANES_W-1:0] planes_reg;
    logic                format_reg;
    logic [WIDTH_W-1:0]  left_reg;
    logic [SEEN_W-1:0]   seen_reg;
    logic [WIDTH_W-1:0]  left_next;
    logic [SEEN_W-1:0]   seen_next;

    logic                job_valid_reg;
    job_t                job_reg;
    job_t                job_next;
    logic                job_ready;

    logic                cfg_wr;
    logic                s_accept;
    logic                push;
    logic [PLANES_W-1:0] planes_eff;
    logic [LANES-1:0][IDX_W-1:0] lane_idx;

    logic [WIDTH_W:0]    width_round;
    logic [SEEN_W-1:0]   row_byte_limit;
    logic [SEEN_W-1:0]   seen_inc;
    logic [WIDTH_W-1:0]  left_eff;
    logic [WIDTH_W-1:0]  left_dec;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = !job_valid_reg || job_ready;
    assign s_accept = s_tvalid && s_tready;

    assign planes_eff = (planes_reg > PLANES_W'(MAX_PLANES)) ? PLANES_W'(MAX_PLANES)
                                                             : planes_reg;

    // Lane l produces pixel l, which comes from bit 7-l of each plane byte.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        p2r_lane #(
            .BIT_POS   (LANES - 1 - l),
            .MAX_PLANES(MAX_PLANES)
        ) u_lane (
            .plane_bytes(s_tdata[PLANE_BYTES_W-1:0]),
            .planes     (planes_eff),
            .idx        (lane_idx[l])
        );
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = CFG_DW'(width_reg);
            REG_NUM_PLANES:   prdata = CFG_DW'(planes_reg);
            REG_IMAGE_FORMAT: prdata = CFG_DW'(format_reg);
            default:          prdata = '0;
        endcase
    end

    // Each row of a plane is padded to a whole number of 16-bit words.
    assign width_round    = {1'b0, width_reg} + (WIDTH_W+1)'(15);
    assign row_byte_limit = {width_round[WIDTH_W:4], 1'b0};
    assign seen_inc       = seen_reg + SEEN_W'(1);
    assign left_eff       = (left_reg == '0) ? width_reg : left_reg;
    assign left_dec       = left_eff - WIDTH_W'(1);

    always_comb begin
        job_next.is_pal = 1'b0;
        job_next.idx    = lane_idx;
        job_next.cnt    = '0;
        job_next.rend   = 1'b0;
        job_next.color  = {s_tdata[77:73], s_tdata[85:81], s_tdata[93:89]};
        left_next       = left_reg;
        seen_next       = seen_reg;

        if (s_tuser == REQ_PAL_WRITE) begin
            job_next.is_pal = 1'b1;
            job_next.idx[0] = s_tdata[71:64];
        end else if (width_reg == '0) begin
            left_next = '0;
            seen_next = '0;
        end else if (format_reg == FMT_CHUNKY) begin
            job_next.idx[0] = s_tdata[7:0];
            job_next.cnt    = CNT_W'(1);
            job_next.rend   = (left_dec == '0);
            left_next       = (left_dec == '0) ? width_reg : left_dec;
            seen_next       = '0;
        end else begin
            if (|left_reg[WIDTH_W-1:3]) begin
                job_next.cnt = CNT_W'(8);
            end else begin
                job_next.cnt = {1'b0, left_reg[2:0]};
            end
            job_next.rend = (left_reg != '0) &&
                            ((left_reg[WIDTH_W-1:3] == '0) || (left_reg == WIDTH_W'(8)));
            if (seen_inc >= row_byte_limit) begin
                left_next = width_reg;
                seen_next = '0;
            end else begin
                left_next = left_reg - WIDTH_W'(job_next.cnt);
                seen_next = seen_inc;
            end
        end
    end

    assign push = s_accept && (job_next.is_pal || (job_next.cnt != '0));

    always_ff @(posedge aclk) begin
        if (push) begin
            job_reg <= job_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= WIDTH_W'(320);
            planes_reg    <= PLANES_W'(8);
            format_reg    <= FMT_PLANAR;
            left_reg      <= WIDTH_W'(320);
            seen_reg      <= '0;
            job_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_IMAGE_WIDTH: begin
                        width_reg <= pwdata[WIDTH_W-1:0];
                        left_reg  <= pwdata[WIDTH_W-1:0];
                        seen_reg  <= '0;
                    end
                    REG_NUM_PLANES: begin
                        planes_reg <= pwdata[PLANES_W-1:0];
                        left_reg   <= width_reg;
                        seen_reg   <= '0;
                    end
                    REG_IMAGE_FORMAT: begin
                        format_reg <= pwdata[0];
                        left_reg   <= width_reg;
                        seen_reg   <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (s_accept) begin
                left_reg <= left_next;
                seen_reg <= seen_next;
            end

            if (push) begin
                job_valid_reg <= 1'b1;
            end else if (job_ready) begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    logic [RGB_W-1:0] out_rgb;

    p2r_serializer #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job_valid(job_valid_reg),
        .job      (job_reg),
        .job_ready(job_ready),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_rgb  (out_rgb),
        .out_last (m_tlast),
        .out_rend (m_tuser)
    );

    assign m_tdata = {1'b0, out_rgb};

endmodule
